// ===== hdl/srmon_pkg.sv =====
`default_nettype none

package srmon_pkg;

  // Table and window geometry
  localparam int unsigned MaxSensors = 16;
  localparam int unsigned Window     = 5;

  localparam int unsigned IdxW     = (MaxSensors > 1) ? $clog2(MaxSensors) : 1;
  localparam int unsigned FillW    = $clog2(Window + 1);
  localparam int unsigned SlotW    = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned TotalW   = 16 + $clog2(Window);
  localparam int unsigned RamDepth = MaxSensors * Window;
  localparam int unsigned CfgIdxW  = 1;

  // Reciprocal for exact truncating division of a TotalW-bit magnitude by Window
  localparam int unsigned RecipShift = TotalW + $clog2(Window);
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << RecipShift) + 64'(Window) - 64'd1) / 64'(Window));
  localparam int unsigned ProdW = TotalW + RecipW;

  // Threshold reset values, signed Q8.8
  localparam logic signed [15:0] MinTempReset = 16'sd2560;
  localparam logic signed [15:0] MaxTempReset = 16'sd5120;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } command_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_TEMP = 1'b0,
    CFG_MAX_TEMP = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_LOADED   = 3'd0,
    ST_FILLING  = 3'd1,
    ST_IN_RANGE = 3'd2,
    ST_TOO_COLD = 3'd3,
    ST_TOO_HOT  = 3'd4,
    ST_UNKNOWN  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_SLIDE,
    S_DIVIDE,
    S_JUDGE,
    S_FINISH
  } state_e;

  typedef struct packed {
    command_e           command;
    logic [3:0]         entry_index;
    logic [15:0]        sensor_tag;
    logic [15:0]        room_id;
    logic signed [15:0] sample_value;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic [15:0]        sensor_echo;
    logic [15:0]        room_of_sensor;
    logic signed [15:0] running_average;
  } out_t;

endpackage

`default_nettype wire

// ===== hdl/srmon_ram.sv =====
`default_nettype none

module srmon_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 80,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port on one address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/per_sensor_running_average_monitor_core.sv =====
`default_nettype none

// Per-sensor running-average monitor. A load transfer (command 0) writes one
// table entry (sensor id, room id) and restarts that entry's sample window; its
// result goes from the FINISH state to the output register. A sample transfer
// (command 1) searches the table one entry per cycle, lowest index first, then
// updates the window in a single-port sample memory and, once the window is
// full, divides the running sum by the window length with one multiply by a
// reciprocal and compares the average with the min/max thresholds. A matching
// sample passes UPDATE, then SLIDE if its window was already full, then DIVIDE
// and JUDGE if the window is now full, then FINISH; an unknown sensor goes to
// FINISH after the last table entry.
// The input side is stalled while an item is in work; the result waits in an
// output register, so the next item is taken while a result is still pending.
// Threshold writes are taken at any time and are meant for idle periods.
module per_sensor_running_average_monitor_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire srmon_pkg::in_t                        in_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output srmon_pkg::out_t                            out_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [srmon_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [15:0]                           cfg_data_i
);

  localparam int unsigned RamAddrW =
    (srmon_pkg::RamDepth > 1) ? $clog2(srmon_pkg::RamDepth) : 1;

  srmon_pkg::state_e state_q, state_d;
  logic [srmon_pkg::IdxW-1:0] scan_q, scan_d;
  logic [srmon_pkg::IdxW-1:0] hit_q, hit_d;
  srmon_pkg::in_t  item_q;
  srmon_pkg::out_t res_q, res_d;
  srmon_pkg::out_t out_q;
  logic            out_valid_q;
  logic signed [15:0] min_q, max_q;

  // Sensor table and per-entry window bookkeeping
  logic [srmon_pkg::MaxSensors-1:0] valid_q;
  logic [15:0]                      sensor_q [srmon_pkg::MaxSensors];
  logic [15:0]                      room_q   [srmon_pkg::MaxSensors];
  logic [srmon_pkg::FillW-1:0]      fill_q   [srmon_pkg::MaxSensors];
  logic signed [srmon_pkg::TotalW-1:0] total_q [srmon_pkg::MaxSensors];
  logic [srmon_pkg::SlotW-1:0]      oldest_q [srmon_pkg::MaxSensors];

  logic [srmon_pkg::ProdW-1:0] prod_q, prod_d;
  logic                        neg_q, neg_d;

  logic                          in_xfer;
  logic                          out_push;
  logic                          load_we;
  logic [srmon_pkg::IdxW-1:0]    load_idx;
  logic                          ent_we;
  logic [srmon_pkg::FillW-1:0]   cur_fill, fill_n;
  logic signed [srmon_pkg::TotalW-1:0] cur_total, total_n, sample_ext;
  logic [srmon_pkg::SlotW-1:0]   cur_oldest, oldest_n, slot;
  logic                          ram_we;
  logic [RamAddrW-1:0]           ram_addr;
  logic [15:0]                   ram_rdata;
  logic [srmon_pkg::TotalW-1:0]  mag;
  logic [15:0]                   quo;
  logic signed [15:0]            avg;

  assign in_stall_o  = (state_q != srmon_pkg::S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_push    = (state_q == srmon_pkg::S_FINISH) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign load_idx   = srmon_pkg::IdxW'(in_i.entry_index);
  assign cur_fill   = fill_q[hit_q];
  assign cur_total  = total_q[hit_q];
  assign cur_oldest = oldest_q[hit_q];
  assign sample_ext = srmon_pkg::TotalW'(item_q.sample_value);

  // Pick the window slot: next free slot while filling, else the oldest one
  assign slot = (state_q == srmon_pkg::S_UPDATE && cur_fill < srmon_pkg::FillW'(srmon_pkg::Window))
              ? cur_fill[srmon_pkg::SlotW-1:0] : cur_oldest;
  assign ram_addr = RamAddrW'(32'(hit_q) * srmon_pkg::Window + 32'(slot));

  srmon_ram #(
    .Width (16),
    .Depth (srmon_pkg::RamDepth)
  ) u_srmon_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (item_q.sample_value),
    .rdata_o (ram_rdata)
  );

  // Sum magnitude and scaled-back quotient
  assign mag = cur_total[srmon_pkg::TotalW-1] ? srmon_pkg::TotalW'(-cur_total)
                                              : srmon_pkg::TotalW'(cur_total);
  assign quo = prod_q[srmon_pkg::RecipShift +: 16];
  assign avg = neg_q ? -$signed(quo) : $signed(quo);

  // Sequencer: next state and datapath controls
  always_comb begin
    state_d  = state_q;
    scan_d   = scan_q;
    hit_d    = hit_q;
    res_d    = res_q;
    prod_d   = prod_q;
    neg_d    = neg_q;
    load_we  = 1'b0;
    ent_we   = 1'b0;
    ram_we   = 1'b0;
    fill_n   = cur_fill;
    total_n  = cur_total;
    oldest_n = cur_oldest;
    case (state_q)
      srmon_pkg::S_IDLE: begin
        if (in_xfer) begin
          res_d.sensor_echo     = in_i.sensor_tag;
          res_d.room_of_sensor  = 16'd0;
          res_d.running_average = 16'sd0;
          res_d.status          = srmon_pkg::ST_UNKNOWN;
          scan_d                = '0;
          if (in_i.command == srmon_pkg::CMD_LOAD) begin
            load_we              = (32'(in_i.entry_index) < srmon_pkg::MaxSensors);
            res_d.status         = srmon_pkg::ST_LOADED;
            res_d.room_of_sensor = in_i.room_id;
            state_d              = srmon_pkg::S_FINISH;
          end else begin
            state_d = srmon_pkg::S_SCAN;
          end
        end
      end
      srmon_pkg::S_SCAN: begin
        if (valid_q[scan_q] && sensor_q[scan_q] == item_q.sensor_tag) begin
          hit_d                = scan_q;
          res_d.room_of_sensor = room_q[scan_q];
          state_d              = srmon_pkg::S_UPDATE;
        end else if (scan_q == srmon_pkg::IdxW'(srmon_pkg::MaxSensors - 1)) begin
          state_d = srmon_pkg::S_FINISH;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      srmon_pkg::S_UPDATE: begin
        if (cur_fill < srmon_pkg::FillW'(srmon_pkg::Window)) begin
          // Window still filling: append
          ram_we  = 1'b1;
          ent_we  = 1'b1;
          total_n = cur_total + sample_ext;
          fill_n  = cur_fill + 1'b1;
          if (fill_n == srmon_pkg::FillW'(srmon_pkg::Window)) begin
            state_d = srmon_pkg::S_DIVIDE;
          end else begin
            res_d.status = srmon_pkg::ST_FILLING;
            state_d      = srmon_pkg::S_FINISH;
          end
        end else begin
          // Window full: oldest sample is being read
          state_d = srmon_pkg::S_SLIDE;
        end
      end
      srmon_pkg::S_SLIDE: begin
        ram_we   = 1'b1;
        ent_we   = 1'b1;
        total_n  = cur_total - srmon_pkg::TotalW'($signed(ram_rdata)) + sample_ext;
        oldest_n = (cur_oldest == srmon_pkg::SlotW'(srmon_pkg::Window - 1))
                 ? '0 : cur_oldest + 1'b1;
        state_d  = srmon_pkg::S_DIVIDE;
      end
      srmon_pkg::S_DIVIDE: begin
        neg_d   = cur_total[srmon_pkg::TotalW-1];
        prod_d  = srmon_pkg::ProdW'(mag) * srmon_pkg::ProdW'(srmon_pkg::Recip);
        state_d = srmon_pkg::S_JUDGE;
      end
      srmon_pkg::S_JUDGE: begin
        res_d.running_average = avg;
        if (avg < min_q) begin
          res_d.status = srmon_pkg::ST_TOO_COLD;
        end else if (avg > max_q) begin
          res_d.status = srmon_pkg::ST_TOO_HOT;
        end else begin
          res_d.status = srmon_pkg::ST_IN_RANGE;
        end
        state_d = srmon_pkg::S_FINISH;
      end
      srmon_pkg::S_FINISH: begin
        if (out_push) begin
          state_d = srmon_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = srmon_pkg::S_IDLE;
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srmon_pkg::S_IDLE;
      scan_q  <= '0;
      hit_q   <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      hit_q   <= hit_d;
    end
  end

  // Threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= srmon_pkg::MinTempReset;
      max_q <= srmon_pkg::MaxTempReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == srmon_pkg::CFG_MIN_TEMP) begin
        min_q <= $signed(cfg_data_i);
      end
      if (cfg_index_i == srmon_pkg::CFG_MAX_TEMP) begin
        max_q <= $signed(cfg_data_i);
      end
    end
  end

  // Entry valid bits and window bookkeeping; a load restarts the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < srmon_pkg::MaxSensors; i++) begin
        fill_q[i]   <= '0;
        total_q[i]  <= '0;
        oldest_q[i] <= '0;
      end
    end else if (load_we) begin
      valid_q[load_idx]  <= 1'b1;
      fill_q[load_idx]   <= '0;
      total_q[load_idx]  <= '0;
      oldest_q[load_idx] <= '0;
    end else if (ent_we) begin
      fill_q[hit_q]   <= fill_n;
      total_q[hit_q]  <= total_n;
      oldest_q[hit_q] <= oldest_n;
    end
  end

  // Table payload, item hold and datapath registers
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      sensor_q[load_idx] <= in_i.sensor_tag;
      room_q[load_idx]   <= in_i.room_id;
    end
    if (in_xfer) begin
      item_q <= in_i;
    end
    res_q  <= res_d;
    prod_q <= prod_d;
    neg_q  <= neg_d;
  end

  // Output valid: set on push, drop once the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_q <= res_q;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/srmon_chk.sv =====
`default_nettype none

module srmon_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire srmon_pkg::in_t                in_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire srmon_pkg::out_t               out_o,
  input wire logic                          cfg_we_i,
  input wire logic [srmon_pkg::CfgIdxW-1:0] cfg_index_i,
  input wire logic [15:0]                   cfg_data_i
);

  logic in_xfer;
  logic cfg_seen;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign cfg_seen = cfg_we_i && (cfg_index_i == srmon_pkg::CFG_MIN_TEMP ||
                                 cfg_index_i == srmon_pkg::CFG_MAX_TEMP ||
                                 cfg_data_i != 16'd0);

  // Block is busy right after it takes an item
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input not stalled after a transfer");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed or dropped");

  // No average on loads, filling windows or unknown sensors
  a_avg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == srmon_pkg::ST_LOADED ||
                    out_o.status == srmon_pkg::ST_FILLING ||
                    out_o.status == srmon_pkg::ST_UNKNOWN)
    |-> out_o.running_average == 16'sd0)
    else $error("nonzero average without a full window");

  // Unknown sensor reports no room
  a_unknown_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == srmon_pkg::ST_UNKNOWN |-> out_o.room_of_sensor == 16'd0)
    else $error("unknown sensor with a room id");

  // A load into an empty output answers, through FINISH and the output register, with its own room
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni || cfg_seen)
    in_xfer && in_i.command == srmon_pkg::CMD_LOAD && !out_valid_o
    |=> ##1 out_valid_o && out_o.status == srmon_pkg::ST_LOADED &&
            out_o.room_of_sensor == $past(in_i.room_id, 2) &&
            out_o.sensor_echo == $past(in_i.sensor_tag, 2))
    else $error("load result missing or wrong");

endmodule

bind per_sensor_running_average_monitor_core srmon_chk u_srmon_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o),
  .cfg_we_i    (cfg_we_i),
  .cfg_index_i (cfg_index_i),
  .cfg_data_i  (cfg_data_i)
);

`default_nettype wire
